### sv/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared widths, codes and word types of the biconnected component finder.
// ----------------------------------------------------------------------------
package bcf_pkg;

	localparam int VTX_W  = 10;
	localparam int TIME_W = 11;
	localparam int CNT_W  = 13;
	localparam int VC_W   = 11;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_RUN  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_VTX = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOT_RUN = 3'd3;
	localparam logic [2:0] ST_NO_MORE = 3'd4;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_EDGE  = 2'd1;
	localparam logic [1:0] KIND_CUT   = 2'd2;
	localparam logic [1:0] KIND_TOTAL = 2'd3;

	typedef struct packed {
		logic [1:0]       func;
		logic [VTX_W-1:0] end_a;
		logic [VTX_W-1:0] end_b;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [1:0]       kind;
		logic [VTX_W-1:0] smaller_end;
		logic [VTX_W-1:0] larger_end;
		logic [CNT_W-1:0] component;
		logic             last_in_component;
		logic [VTX_W-1:0] cut_vertex;
		logic [CNT_W-1:0] component_total;
	} res_t;

endpackage

### sv/bcf_if.sv
// ----------------------------------------------------------------------------
// bcf_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface bcf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [9:0] end_a;
	logic [9:0] end_b;

	modport source (output valid, func, end_a, end_b, input ready);
	modport sink   (input valid, func, end_a, end_b, output ready);
endinterface

interface bcf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  kind;
	logic [9:0]  smaller_end;
	logic [9:0]  larger_end;
	logic [12:0] component;
	logic        last_in_component;
	logic [9:0]  cut_vertex;
	logic [12:0] component_total;

	modport source (output valid, status, kind, smaller_end, larger_end, component,
		last_in_component, cut_vertex, component_total, input ready);
	modport sink   (input valid, status, kind, smaller_end, larger_end, component,
		last_in_component, cut_vertex, component_total, output ready);
endinterface

### sv/bcf_ram.sv
// ----------------------------------------------------------------------------
// bcf_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bcf_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### sv/bcf_engine.sv
// ----------------------------------------------------------------------------
// bcf_engine
// Edge store, depth-first search, component sort and result store sequencer.
// ----------------------------------------------------------------------------
module bcf_engine #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bcf_pkg::cmd_t             cmd,
	input  logic [bcf_pkg::VC_W-1:0]  vcount,
	output logic                      busy,
	output logic                      done,
	output bcf_pkg::res_t             res
);

	localparam int VW    = bcf_pkg::VTX_W;
	localparam int TW    = bcf_pkg::TIME_W;
	localparam int SLOTS = 2 * MAX_EDGES;
	localparam int VAW   = $clog2(MAX_VERTICES);
	localparam int DW    = $clog2(MAX_VERTICES + 1);
	localparam int EW    = $clog2(SLOTS + 1);
	localparam int EAW   = $clog2(SLOTS);
	localparam int ESAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW   = $clog2(MAX_EDGES + 1);
	localparam int RES_D = MAX_EDGES + MAX_VERTICES;
	localparam int RSAW  = $clog2(RES_D);
	localparam int RCW   = $clog2(RES_D + 2);
	localparam int FW    = 2 * VW + 1 + EW + 2 + 2 * TW;
	localparam logic [EW-1:0] NIL = EW'(SLOTS);

	localparam logic [5:0] S_CLR_LIST = 6'd0;
	localparam logic [5:0] S_IDLE     = 6'd1;
	localparam logic [5:0] S_LD_RD    = 6'd2;
	localparam logic [5:0] S_LD_WR1   = 6'd3;
	localparam logic [5:0] S_LD_WR2   = 6'd4;
	localparam logic [5:0] S_RN_CLR   = 6'd5;
	localparam logic [5:0] S_RN_ROOT  = 6'd6;
	localparam logic [5:0] S_RN_CHK   = 6'd7;
	localparam logic [5:0] S_EN_RD    = 6'd8;
	localparam logic [5:0] S_EN_SET   = 6'd9;
	localparam logic [5:0] S_SC_CHK   = 6'd10;
	localparam logic [5:0] S_SC_T     = 6'd11;
	localparam logic [5:0] S_SC_D     = 6'd12;
	localparam logic [5:0] S_PO_GOT   = 6'd13;
	localparam logic [5:0] S_CC_POP   = 6'd14;
	localparam logic [5:0] S_CC_GOT   = 6'd15;
	localparam logic [5:0] S_SO_I     = 6'd16;
	localparam logic [5:0] S_SO_K     = 6'd17;
	localparam logic [5:0] S_SO_J     = 6'd18;
	localparam logic [5:0] S_SO_C     = 6'd19;
	localparam logic [5:0] S_ME_RD    = 6'd20;
	localparam logic [5:0] S_ME_GOT   = 6'd21;
	localparam logic [5:0] S_ME_END   = 6'd22;
	localparam logic [5:0] S_CS_RD    = 6'd23;
	localparam logic [5:0] S_CS_GOT   = 6'd24;
	localparam logic [5:0] S_RD_RD    = 6'd25;
	localparam logic [5:0] S_RD_GOT   = 6'd26;

	logic [5:0]     state_q;
	logic [VAW:0]   sw_q;
	logic [EW-1:0]  ecount_q;
	logic           run_done_q;
	logic [VW-1:0]  ldx_q, ldy_q;
	logic           ldsecond_q, lempty_q;
	logic [EW-1:0]  ltail_q;
	logic [TW-1:0]  clock_q;
	logic [VW:0]    root_q, cs_q;
	logic [VW-1:0]  tv_q, tp_q, w_q, cu_q, stop_u_q, stop_w_q;
	logic           troot_q, match_q, ret_q;
	logic [EW-1:0]  tit_q;
	logic [1:0]     tch_q;
	logic [TW-1:0]  tlow_q, tdisc_q, clow_q;
	logic [DW-1:0]  depth_q;
	logic [ECW-1:0] ed_q, k_q, i_q, j_q, comp_q;
	logic [ECW:0]   rc_q;
	logic [19:0]    key_q, pend_q;
	logic [RCW-1:0] re_q, ct_q, rp_q;
	logic           done_q;
	bcf_pkg::res_t  res_q;

	logic [VW:0]    n;

	logic              lst_we;
	logic [VAW-1:0]    lst_waddr, lst_raddr;
	logic [2*EW-1:0]   lst_wdata, lst_rdata;
	logic              nxt_we;
	logic [EAW-1:0]    nxt_waddr, ent_raddr;
	logic [EW-1:0]     nxt_wdata, nxt_rdata;
	logic              tgt_we;
	logic [VW-1:0]     tgt_rdata;
	logic              dc_we;
	logic [VAW-1:0]    dc_waddr, dc_raddr;
	logic [TW:0]       dc_wdata, dc_rdata;
	logic              stk_we;
	logic [VAW-1:0]    stk_waddr, stk_raddr;
	logic [FW-1:0]     stk_wdata, stk_rdata;
	logic              edg_we;
	logic [ESAW-1:0]   edg_waddr, edg_raddr;
	logic [19:0]       edg_wdata, edg_rdata;
	logic              scr_we;
	logic [ESAW-1:0]   scr_waddr, scr_raddr;
	logic [19:0]       scr_wdata, scr_rdata;
	logic              rs_we;
	logic [RSAW-1:0]   rs_waddr, rs_raddr;
	logic [20:0]       rs_wdata, rs_rdata;

	logic [EW-1:0]  lhead, ltail;
	logic [VW-1:0]  f_v, f_p, e_a, e_b;
	logic           f_root;
	logic [EW-1:0]  f_it;
	logic [1:0]     f_ch;
	logic [TW-1:0]  f_low, f_disc, d_w;

	assign n = (int'(vcount) < MAX_VERTICES) ? vcount : (VW + 1)'(MAX_VERTICES);
	assign {lhead, ltail} = lst_rdata;
	assign {f_v, f_p, f_root, f_it, f_ch, f_low, f_disc} = stk_rdata;
	assign {e_a, e_b} = edg_rdata;
	assign d_w = dc_rdata[TW-1:0];

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	always_comb begin
		lst_we = 1'b0; lst_waddr = '0; lst_wdata = '0; lst_raddr = '0;
		nxt_we = 1'b0; nxt_waddr = '0; nxt_wdata = '0; ent_raddr = '0;
		tgt_we = 1'b0;
		dc_we = 1'b0; dc_waddr = '0; dc_wdata = '0; dc_raddr = '0;
		stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
		edg_we = 1'b0; edg_waddr = '0; edg_wdata = '0; edg_raddr = '0;
		scr_we = 1'b0; scr_waddr = '0; scr_wdata = '0; scr_raddr = '0;
		rs_we = 1'b0; rs_waddr = '0; rs_wdata = '0; rs_raddr = '0;
		case (state_q)
			S_CLR_LIST: begin
				lst_we    = 1'b1;
				lst_waddr = sw_q[VAW-1:0];
				lst_wdata = {NIL, NIL};
			end
			S_LD_RD: lst_raddr = VAW'(ldx_q);
			S_LD_WR1: begin
				lst_we    = 1'b1;
				lst_waddr = VAW'(ldx_q);
				lst_wdata = (lhead >= NIL) ? {ecount_q, ecount_q} : {lhead, ecount_q};
				nxt_we    = 1'b1;
				nxt_waddr = EAW'(ecount_q);
				nxt_wdata = NIL;
				tgt_we    = 1'b1;
			end
			S_LD_WR2: begin
				nxt_we    = !lempty_q;
				nxt_waddr = EAW'(ltail_q);
				nxt_wdata = ecount_q;
			end
			S_RN_CLR: begin
				dc_we    = 1'b1;
				dc_waddr = sw_q[VAW-1:0];
			end
			S_RN_ROOT: dc_raddr = VAW'(root_q);
			S_EN_RD: begin
				lst_raddr = VAW'(tv_q);
				dc_we     = 1'b1;
				dc_waddr  = VAW'(tv_q);
				dc_wdata  = {1'b0, tdisc_q};
			end
			S_SC_CHK: begin
				ent_raddr = EAW'(tit_q);
				stk_raddr = VAW'(depth_q - DW'(2));
				dc_we     = (tit_q >= NIL) && troot_q && (tch_q > 2'd1);
				dc_waddr  = VAW'(tv_q);
				dc_wdata  = {1'b1, tdisc_q};
			end
			S_SC_T: dc_raddr = VAW'(tgt_rdata);
			S_SC_D: begin
				edg_we    = (d_w == '0) || (d_w < tdisc_q);
				edg_waddr = ESAW'(ed_q);
				edg_wdata = {tv_q, w_q};
				stk_we    = (d_w == '0);
				stk_waddr = VAW'(depth_q - DW'(1));
				stk_wdata = {tv_q, tp_q, troot_q, tit_q,
					(tch_q == 2'd3) ? tch_q : tch_q + 2'd1, tlow_q, tdisc_q};
			end
			S_PO_GOT: begin
				dc_we    = (clow_q >= f_disc) && (depth_q > DW'(1));
				dc_waddr = VAW'(f_v);
				dc_wdata = {1'b1, f_disc};
			end
			S_CC_POP: edg_raddr = ESAW'(ed_q - ECW'(1));
			S_CC_GOT: begin
				scr_we    = 1'b1;
				scr_waddr = ESAW'(k_q);
				scr_wdata = (e_a < e_b) ? {e_a, e_b} : {e_b, e_a};
			end
			S_SO_I: scr_raddr = ESAW'(i_q);
			S_SO_J: begin
				scr_raddr = ESAW'(j_q - ECW'(1));
				scr_we    = (j_q == '0);
				scr_waddr = '0;
				scr_wdata = key_q;
			end
			S_SO_C: begin
				scr_we    = 1'b1;
				scr_waddr = ESAW'(j_q);
				scr_wdata = (scr_rdata > key_q) ? scr_rdata : key_q;
			end
			S_ME_RD: scr_raddr = ESAW'(i_q);
			S_ME_GOT: begin
				rs_we    = (i_q != '0) && (scr_rdata != pend_q);
				rs_waddr = RSAW'(re_q);
				rs_wdata = {1'b0, pend_q};
			end
			S_ME_END: begin
				rs_we    = 1'b1;
				rs_waddr = RSAW'(re_q);
				rs_wdata = {1'b1, pend_q};
			end
			S_CS_RD: dc_raddr = VAW'(cs_q);
			S_CS_GOT: begin
				rs_we    = dc_rdata[TW];
				rs_waddr = RSAW'(re_q + ct_q);
				rs_wdata = 21'(cs_q[VW-1:0]);
			end
			S_RD_RD: rs_raddr = RSAW'(rp_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR_LIST;
			sw_q       <= '0;
			ecount_q   <= '0;
			run_done_q <= 1'b0;
			clock_q    <= '0;
			depth_q    <= '0;
			ed_q       <= '0;
			re_q       <= '0;
			ct_q       <= '0;
			comp_q     <= '0;
			rp_q       <= '0;
			rc_q       <= (ECW + 1)'(1);
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLR_LIST: begin
					if (int'(sw_q) == MAX_VERTICES - 1)
						state_q <= S_IDLE;
					else
						sw_q <= sw_q + 1'b1;
				end
				S_IDLE: begin
					if (start) begin
						res_q <= '0;
						case (cmd.func)
							bcf_pkg::FUNC_LOAD: begin
								if ({1'b0, cmd.end_a} >= n || {1'b0, cmd.end_b} >= n) begin
									res_q.status <= bcf_pkg::ST_BAD_VTX;
									done_q       <= 1'b1;
								end else if (int'(ecount_q) + 2 > SLOTS) begin
									res_q.status <= bcf_pkg::ST_FULL;
									done_q       <= 1'b1;
								end else begin
									ldx_q      <= cmd.end_a;
									ldy_q      <= cmd.end_b;
									ldsecond_q <= 1'b0;
									state_q    <= S_LD_RD;
								end
							end
							bcf_pkg::FUNC_RUN: begin
								sw_q     <= '0;
								clock_q  <= '0;
								depth_q  <= '0;
								ed_q     <= '0;
								re_q     <= '0;
								ct_q     <= '0;
								comp_q   <= '0;
								root_q   <= '0;
								state_q  <= S_RN_CLR;
							end
							bcf_pkg::FUNC_READ: begin
								if (!run_done_q) begin
									res_q.status <= bcf_pkg::ST_NOT_RUN;
									done_q       <= 1'b1;
								end else if (rp_q < re_q + ct_q) begin
									state_q <= S_RD_RD;
								end else if (rp_q == re_q + ct_q) begin
									res_q.kind            <= bcf_pkg::KIND_TOTAL;
									res_q.component_total <= bcf_pkg::CNT_W'(comp_q);
									rp_q                  <= rp_q + 1'b1;
									done_q                <= 1'b1;
								end else begin
									res_q.status <= bcf_pkg::ST_NO_MORE;
									done_q       <= 1'b1;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_LD_RD: state_q <= S_LD_WR1;
				S_LD_WR1: begin
					lempty_q <= (lhead >= NIL);
					ltail_q  <= ltail;
					state_q  <= S_LD_WR2;
				end
				S_LD_WR2: begin
					ecount_q <= ecount_q + 1'b1;
					if (!ldsecond_q) begin
						ldsecond_q <= 1'b1;
						ldx_q      <= ldy_q;
						ldy_q      <= ldx_q;
						state_q    <= S_LD_RD;
					end else begin
						run_done_q <= 1'b0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				S_RN_CLR: begin
					if (int'(sw_q) == MAX_VERTICES - 1)
						state_q <= S_RN_ROOT;
					else
						sw_q <= sw_q + 1'b1;
				end
				S_RN_ROOT: begin
					if (root_q == n) begin
						cs_q    <= '0;
						state_q <= S_CS_RD;
					end else begin
						state_q <= S_RN_CHK;
					end
				end
				S_RN_CHK: begin
					if (d_w != '0) begin
						root_q  <= root_q + 1'b1;
						state_q <= S_RN_ROOT;
					end else begin
						clock_q <= clock_q + 1'b1;
						tv_q    <= root_q[VW-1:0];
						tp_q    <= '0;
						troot_q <= 1'b1;
						tch_q   <= '0;
						tlow_q  <= clock_q + 1'b1;
						tdisc_q <= clock_q + 1'b1;
						depth_q <= DW'(1);
						state_q <= S_EN_RD;
					end
				end
				S_EN_RD: state_q <= S_EN_SET;
				S_EN_SET: begin
					tit_q   <= lhead;
					state_q <= S_SC_CHK;
				end
				S_SC_CHK: begin
					if (tit_q < NIL) begin
						state_q <= S_SC_T;
					end else if (troot_q) begin
						match_q <= 1'b0;
						k_q     <= '0;
						ret_q   <= 1'b1;
						depth_q <= depth_q - 1'b1;
						state_q <= S_CC_POP;
					end else begin
						cu_q    <= tv_q;
						clow_q  <= tlow_q;
						depth_q <= depth_q - 1'b1;
						state_q <= S_PO_GOT;
					end
				end
				S_SC_T: begin
					tit_q <= nxt_rdata;
					w_q   <= tgt_rdata;
					if ({1'b0, tgt_rdata} >= n || (!troot_q && tgt_rdata == tp_q))
						state_q <= S_SC_CHK;
					else
						state_q <= S_SC_D;
				end
				S_SC_D: begin
					if (d_w != '0) begin
						if (d_w < tlow_q)
							tlow_q <= d_w;
						if (d_w < tdisc_q)
							ed_q <= ed_q + 1'b1;
						state_q <= S_SC_CHK;
					end else begin
						ed_q    <= ed_q + 1'b1;
						clock_q <= clock_q + 1'b1;
						tp_q    <= tv_q;
						tv_q    <= w_q;
						troot_q <= 1'b0;
						tch_q   <= '0;
						tlow_q  <= clock_q + 1'b1;
						tdisc_q <= clock_q + 1'b1;
						depth_q <= depth_q + 1'b1;
						state_q <= S_EN_RD;
					end
				end
				S_PO_GOT: begin
					tv_q    <= f_v;
					tp_q    <= f_p;
					troot_q <= f_root;
					tit_q   <= f_it;
					tch_q   <= f_ch;
					tdisc_q <= f_disc;
					tlow_q  <= (clow_q < f_low) ? clow_q : f_low;
					if (clow_q >= f_disc) begin
						match_q  <= 1'b1;
						stop_u_q <= f_v;
						stop_w_q <= cu_q;
						k_q      <= '0;
						ret_q    <= 1'b0;
						state_q  <= S_CC_POP;
					end else begin
						state_q <= S_SC_CHK;
					end
				end
				S_CC_POP: begin
					if (ed_q == '0) begin
						if (k_q == '0) begin
							if (ret_q) begin
								root_q  <= root_q + 1'b1;
								state_q <= S_RN_ROOT;
							end else begin
								state_q <= S_SC_CHK;
							end
						end else begin
							i_q     <= ECW'(1);
							state_q <= S_SO_I;
						end
					end else begin
						ed_q    <= ed_q - 1'b1;
						state_q <= S_CC_GOT;
					end
				end
				S_CC_GOT: begin
					k_q <= k_q + 1'b1;
					if (match_q && e_a == stop_u_q && e_b == stop_w_q) begin
						i_q     <= ECW'(1);
						state_q <= S_SO_I;
					end else begin
						state_q <= S_CC_POP;
					end
				end
				S_SO_I: begin
					if (i_q >= k_q) begin
						i_q     <= '0;
						state_q <= S_ME_RD;
					end else begin
						state_q <= S_SO_K;
					end
				end
				S_SO_K: begin
					key_q   <= scr_rdata;
					j_q     <= i_q;
					state_q <= S_SO_J;
				end
				S_SO_J: begin
					if (j_q == '0) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SO_I;
					end else begin
						state_q <= S_SO_C;
					end
				end
				S_SO_C: begin
					if (scr_rdata > key_q) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_SO_J;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SO_I;
					end
				end
				S_ME_RD: begin
					if (i_q == k_q)
						state_q <= S_ME_END;
					else
						state_q <= S_ME_GOT;
				end
				S_ME_GOT: begin
					if (i_q == '0) begin
						pend_q <= scr_rdata;
					end else if (scr_rdata != pend_q) begin
						re_q   <= re_q + 1'b1;
						pend_q <= scr_rdata;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_ME_RD;
				end
				S_ME_END: begin
					re_q   <= re_q + 1'b1;
					comp_q <= comp_q + 1'b1;
					if (ret_q) begin
						root_q  <= root_q + 1'b1;
						state_q <= S_RN_ROOT;
					end else begin
						state_q <= S_SC_CHK;
					end
				end
				S_CS_RD: begin
					if (cs_q == n) begin
						rp_q       <= '0;
						rc_q       <= (ECW + 1)'(1);
						run_done_q <= 1'b1;
						res_q      <= '0;
						done_q     <= 1'b1;
						state_q    <= S_IDLE;
					end else begin
						state_q <= S_CS_GOT;
					end
				end
				S_CS_GOT: begin
					if (dc_rdata[TW])
						ct_q <= ct_q + 1'b1;
					cs_q    <= cs_q + 1'b1;
					state_q <= S_CS_RD;
				end
				S_RD_RD: state_q <= S_RD_GOT;
				S_RD_GOT: begin
					if (rp_q < re_q) begin
						res_q.kind              <= bcf_pkg::KIND_EDGE;
						res_q.smaller_end       <= rs_rdata[19:10];
						res_q.larger_end        <= rs_rdata[9:0];
						res_q.component         <= bcf_pkg::CNT_W'(rc_q);
						res_q.last_in_component <= rs_rdata[20];
						if (rs_rdata[20])
							rc_q <= rc_q + 1'b1;
					end else begin
						res_q.kind       <= bcf_pkg::KIND_CUT;
						res_q.cut_vertex <= rs_rdata[9:0];
					end
					rp_q    <= rp_q + 1'b1;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	bcf_ram #(.W(2 * EW), .D(MAX_VERTICES)) u_list (
		.clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
		.raddr(lst_raddr), .rdata(lst_rdata));

	bcf_ram #(.W(EW), .D(SLOTS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
		.raddr(ent_raddr), .rdata(nxt_rdata));

	bcf_ram #(.W(VW), .D(SLOTS)) u_target (
		.clk(clk), .we(tgt_we), .waddr(EAW'(ecount_q)), .wdata(ldy_q),
		.raddr(ent_raddr), .rdata(tgt_rdata));

	bcf_ram #(.W(TW + 1), .D(MAX_VERTICES)) u_disc (
		.clk(clk), .we(dc_we), .waddr(dc_waddr), .wdata(dc_wdata),
		.raddr(dc_raddr), .rdata(dc_rdata));

	bcf_ram #(.W(FW), .D(MAX_VERTICES)) u_frames (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata));

	bcf_ram #(.W(20), .D(MAX_EDGES)) u_edges (
		.clk(clk), .we(edg_we), .waddr(edg_waddr), .wdata(edg_wdata),
		.raddr(edg_raddr), .rdata(edg_rdata));

	bcf_ram #(.W(20), .D(MAX_EDGES)) u_scratch (
		.clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
		.raddr(scr_raddr), .rdata(scr_rdata));

	bcf_ram #(.W(21), .D(RES_D)) u_results (
		.clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
		.raddr(rs_raddr), .rdata(rs_rdata));

endmodule

### sv/biconnected_component_finder.sv
// ----------------------------------------------------------------------------
// biconnected_component_finder
// Biconnected components and cut vertices of an undirected graph.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  req       in   valid/ready       func, end_a, end_b
//  rsp       out  valid/ready       status, kind, edge, component, cut, total
//  cfg       in   cfg_wen           cfg_data (vertex_count)
//
//  Load: two list read/write rounds. Run: a clear of the discovery table, a
//  depth-first walk of the adjacency entries, stacked edge pops, an insertion
//  sort of each component and a cut scan over the vertices. After reset a list
//  clear runs with req.ready low. A stalled rsp word holds; req.ready drops while
//  it waits.
// ----------------------------------------------------------------------------
module biconnected_component_finder #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	bcf_in_if.sink                   req,
	bcf_out_if.source                rsp,
	input  logic                     cfg_wen,
	input  logic [bcf_pkg::VC_W-1:0] cfg_data
);

	logic [bcf_pkg::VC_W-1:0] vcount_q;
	logic                     busy, done, start, ov_q;
	bcf_pkg::cmd_t            cmd;
	bcf_pkg::res_t            res, out_q;

	assign req.ready = !busy && !done && (!ov_q || rsp.ready);
	assign start     = req.valid && req.ready;
	assign cmd       = '{func: req.func, end_a: req.end_a, end_b: req.end_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_wen)
				vcount_q <= cfg_data;
			if (done)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= res;
	end

	assign rsp.valid             = ov_q;
	assign rsp.status            = out_q.status;
	assign rsp.kind              = out_q.kind;
	assign rsp.smaller_end       = out_q.smaller_end;
	assign rsp.larger_end        = out_q.larger_end;
	assign rsp.component         = out_q.component;
	assign rsp.last_in_component = out_q.last_in_component;
	assign rsp.cut_vertex        = out_q.cut_vertex;
	assign rsp.component_total   = out_q.component_total;

	bcf_engine #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .vcount(vcount_q),
		.busy(busy), .done(done), .res(res));

endmodule

### sv/bcf_checker.sv
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks of the biconnected component finder.
// ----------------------------------------------------------------------------
module bcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [1:0]  kind,
	input logic [9:0]  smaller_end,
	input logic [9:0]  larger_end,
	input logic [12:0] component,
	input logic        last_in_component,
	input logic [9:0]  cut_vertex,
	input logic [12:0] component_total
);

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_ready)
		else $error("command word taken while result word blocked");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(kind) && $stable(status))
		else $error("result word changed while stalled");

	a_ack_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == bcf_pkg::KIND_ACK |-> smaller_end == '0 &&
		larger_end == '0 && component == '0 && !last_in_component &&
		cut_vertex == '0 && component_total == '0)
		else $error("acknowledge word carries data");

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == bcf_pkg::KIND_EDGE |-> status == bcf_pkg::ST_OK &&
		smaller_end <= larger_end && component != '0)
		else $error("bad component edge word");

endmodule

bind biconnected_component_finder bcf_checker u_bcf_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(req.valid), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready),
	.status(rsp.status), .kind(rsp.kind),
	.smaller_end(rsp.smaller_end), .larger_end(rsp.larger_end),
	.component(rsp.component), .last_in_component(rsp.last_in_component),
	.cut_vertex(rsp.cut_vertex), .component_total(rsp.component_total));

### tb/biconnected_component_finder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biconnected_component_finder_tb
// Loads small and large graphs, runs the search and reads result words,
// checking each word against an in-bench depth-first-search predictor.
// ----------------------------------------------------------------------------
module biconnected_component_finder_tb;

	localparam int          MAX_V      = 1024;
	localparam int          SLOTS      = 8192;
	localparam int          NIL        = SLOTS;
	localparam int          NO_PARENT  = -1;
	localparam int          STALL_MAX  = 200000;
	localparam logic [1:0]  FUNC_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [bcf_pkg::VC_W-1:0] cfg_data;

	bcf_in_if  req();
	bcf_out_if rsp();

	biconnected_component_finder dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_wen(cfg_wen), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// predictor state
	int vcount;
	int head[MAX_V], tail[MAX_V], nxt[SLOTS], tgt[SLOTS];
	int n_entries;
	int disc[MAX_V], lowv[MAX_V];
	bit cutf[MAX_V];
	int vclock;
	int fv[MAX_V], fp[MAX_V], fit[MAX_V], fch[MAX_V];
	int fdepth;
	int es_u[SLOTS], es_w[SLOTS];
	int edepth;
	int rs_key[SLOTS];
	bit rs_last[SLOTS];
	int n_res;
	int scr[SLOTS];
	int cuts[MAX_V];
	int n_cuts, n_comp, rptr, rcomp;
	bit ran;

	bcf_pkg::cmd_t pend_cmds[$];
	bcf_pkg::res_t expected_words[$];
	int   send_idle, recv_idle;
	int   fails;
	int   stall;

	function automatic int active_n();
		return (vcount < MAX_V) ? vcount : MAX_V;
	endfunction

	task automatic append_entry(input int x, input int y);
		int idx;
		idx = n_entries;
		n_entries++;
		tgt[idx] = y;
		nxt[idx] = NIL;
		if (head[x] >= SLOTS) head[x] = idx;
		else nxt[tail[x]] = idx;
		tail[x] = idx;
	endtask

	task automatic push_pair(input int u, input int w);
		if (edepth < SLOTS) begin
			es_u[edepth] = u;
			es_w[edepth] = w;
			edepth++;
		end
	endtask

	task automatic close_component(input int su, input int sw, input bit matching);
		int k, i, j, a, b, key;
		k = 0;
		while (edepth > 0) begin
			edepth--;
			a = es_u[edepth];
			b = es_w[edepth];
			scr[k] = (a < b) ? (a * 65536 + b) : (b * 65536 + a);
			k++;
			if (matching && a == su && b == sw) break;
		end
		if (k == 0) return;
		for (i = 1; i < k; i++) begin
			key = scr[i];
			j = i;
			while (j > 0 && scr[j-1] > key) begin
				scr[j] = scr[j-1];
				j--;
			end
			scr[j] = key;
		end
		for (i = 0; i < k; i++) begin
			if (i > 0 && scr[i] == scr[i-1]) continue;
			if (n_res < SLOTS) begin
				rs_key[n_res] = scr[i];
				rs_last[n_res] = 1'b0;
				n_res++;
			end
		end
		if (n_res > 0) rs_last[n_res-1] = 1'b1;
		n_comp++;
	endtask

	task automatic enter_vertex(input int w, input int par);
		vclock++;
		disc[w] = vclock;
		lowv[w] = vclock;
		if (fdepth < MAX_V) begin
			fv[fdepth] = w;
			fp[fdepth] = par;
			fit[fdepth] = head[w];
			fch[fdepth] = 0;
			fdepth++;
		end
	endtask

	task automatic search_from(input int root, input int n);
		int top, u, e, w, par, ch;
		enter_vertex(root, NO_PARENT);
		while (fdepth > 0) begin
			top = fdepth - 1;
			u = fv[top];
			if (fit[top] < SLOTS) begin
				e = fit[top];
				fit[top] = nxt[e];
				w = tgt[e];
				if (w >= n || w == fp[top]) continue;
				if (disc[w] != 0) begin
					if (disc[w] < lowv[u]) lowv[u] = disc[w];
					if (disc[w] < disc[u]) push_pair(u, w);
				end else begin
					fch[top]++;
					push_pair(u, w);
					enter_vertex(w, u);
				end
			end else begin
				par = fp[top];
				ch = fch[top];
				fdepth--;
				if (par == NO_PARENT) begin
					if (ch > 1) cutf[u] = 1'b1;
				end else begin
					if (lowv[u] < lowv[par]) lowv[par] = lowv[u];
					if (lowv[u] >= disc[par]) begin
						if (fdepth > 0 && fp[fdepth-1] != NO_PARENT) cutf[par] = 1'b1;
						close_component(par, u, 1'b1);
					end
				end
			end
		end
		close_component(0, 0, 1'b0);
	endtask

	task automatic run_search();
		int n, r;
		n = active_n();
		for (r = 0; r < MAX_V; r++) begin
			disc[r] = 0;
			lowv[r] = 0;
			cutf[r] = 1'b0;
		end
		vclock = 0; fdepth = 0; edepth = 0; n_res = 0; n_comp = 0; n_cuts = 0;
		for (r = 0; r < n; r++)
			if (disc[r] == 0) search_from(r, n);
		for (r = 0; r < n; r++)
			if (cutf[r]) begin
				cuts[n_cuts] = r;
				n_cuts++;
			end
		rptr = 0;
		rcomp = 1;
		ran = 1'b1;
	endtask

	// work out the result word of one accepted command word
	task automatic predict_word(input bcf_pkg::cmd_t c);
		bcf_pkg::res_t r;
		int n, a, b;
		r = '0;
		n = active_n();
		a = c.end_a;
		b = c.end_b;
		r.status = bcf_pkg::ST_OK;
		r.kind = bcf_pkg::KIND_ACK;
		case (c.func)
			bcf_pkg::FUNC_LOAD: begin
				if (a >= n || b >= n) r.status = bcf_pkg::ST_BAD_VTX;
				else if (n_entries + 2 > SLOTS) r.status = bcf_pkg::ST_FULL;
				else begin
					append_entry(a, b);
					append_entry(b, a);
					ran = 1'b0;
				end
			end
			bcf_pkg::FUNC_RUN: run_search();
			bcf_pkg::FUNC_READ: begin
				if (!ran) r.status = bcf_pkg::ST_NOT_RUN;
				else if (rptr < n_res) begin
					r.kind = bcf_pkg::KIND_EDGE;
					r.smaller_end = 10'(rs_key[rptr] / 65536);
					r.larger_end = 10'(rs_key[rptr] % 65536);
					r.component = 13'(rcomp);
					r.last_in_component = rs_last[rptr];
					if (rs_last[rptr]) rcomp++;
					rptr++;
				end else if (rptr < n_res + n_cuts) begin
					r.kind = bcf_pkg::KIND_CUT;
					r.cut_vertex = 10'(cuts[rptr - n_res]);
					rptr++;
				end else if (rptr == n_res + n_cuts) begin
					r.kind = bcf_pkg::KIND_TOTAL;
					r.component_total = 13'(n_comp);
					rptr++;
				end else r.status = bcf_pkg::ST_NO_MORE;
			end
			default: ;
		endcase
		expected_words = {expected_words, r};
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= bcf_pkg::FUNC_LOAD;
			req.end_a <= '0;
			req.end_b <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predict_word(pend_cmds[0]);
				void'(pend_cmds.pop_front());
			end
			if (!(req.valid && !req.ready)) begin
				if (pend_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
					req.valid <= 1'b1;
					req.func <= pend_cmds[0].func;
					req.end_a <= pend_cmds[0].end_a;
					req.end_b <= pend_cmds[0].end_b;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall <= 0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle);
			if (rsp.valid && rsp.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, actual status %0d kind %0d",
						$time, rsp.status, rsp.kind);
					fails++;
				end else begin
					check_field("status", expected_words[0].status, rsp.status);
					check_field("kind", expected_words[0].kind, rsp.kind);
					check_field("smaller_end", expected_words[0].smaller_end, rsp.smaller_end);
					check_field("larger_end", expected_words[0].larger_end, rsp.larger_end);
					check_field("component", expected_words[0].component, rsp.component);
					check_field("last_in_component", expected_words[0].last_in_component,
						rsp.last_in_component);
					check_field("cut_vertex", expected_words[0].cut_vertex, rsp.cut_vertex);
					check_field("component_total", expected_words[0].component_total,
						rsp.component_total);
					void'(expected_words.pop_front());
				end
			end
			if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) stall <= 0;
			else stall <= stall + 1;
			if (stall >= STALL_MAX) begin
				$display("[biconnected_component_finder] ERROR");
				$finish;
			end
		end
	end

	task automatic push_cmd(input logic [1:0] f, input int a, input int b);
		bcf_pkg::cmd_t c;
		c.func = f;
		c.end_a = 10'(a);
		c.end_b = 10'(b);
		pend_cmds = {pend_cmds, c};
	endtask

	task automatic drain();
		while (pend_cmds.size() > 0 || expected_words.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_vcount(input int v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_data <= bcf_pkg::VC_W'(v);
		vcount = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// one random graph: loads with some noise, a run, then reads
	task automatic random_graph(input int nv, inout int issued);
		int ne, i, a, b;
		ne = $urandom_range(2, 14);
		for (i = 0; i < ne; i++) begin
			a = $urandom_range(nv - 1);
			b = $urandom_range(nv - 1);
			case ($urandom_range(19))
				0: b = a;
				1: b = $urandom_range(nv, 1023);
				2: push_cmd(bcf_pkg::FUNC_READ, 0, 0);
				3: push_cmd(FUNC_SPARE, $urandom_range(1023), $urandom_range(1023));
				default: ;
			endcase
			push_cmd(bcf_pkg::FUNC_LOAD, a, b);
		end
		push_cmd(bcf_pkg::FUNC_RUN, $urandom_range(1023), $urandom_range(1023));
		for (i = 0; i < ne + nv / 2 + 2; i++) push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		issued += 2 * ne + nv / 2 + 3;
	endtask

	initial begin
		int issued, nv, i, k;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_data = '0;
		fails = 0;
		send_idle = 29;
		recv_idle = 45;
		vcount = 0;
		for (i = 0; i < MAX_V; i++) begin
			head[i] = NIL;
			tail[i] = NIL;
			disc[i] = 0;
			cutf[i] = 1'b0;
		end
		n_entries = 0; vclock = 0; fdepth = 0; edepth = 0; n_res = 0;
		n_cuts = 0; n_comp = 0; rptr = 0; rcomp = 1; ran = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty graph with no vertices
		push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		push_cmd(bcf_pkg::FUNC_LOAD, 0, 0);
		push_cmd(bcf_pkg::FUNC_RUN, 0, 0);
		push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		push_cmd(FUNC_SPARE, 1023, 1023);
		drain();

		// extremes, self loop, parallel edges, triangle with a bridge
		write_vcount(2047);
		push_cmd(bcf_pkg::FUNC_LOAD, 1023, 0);
		push_cmd(bcf_pkg::FUNC_LOAD, 0, 1023);
		push_cmd(bcf_pkg::FUNC_LOAD, 1023, 1023);
		push_cmd(bcf_pkg::FUNC_LOAD, 5, 6);
		push_cmd(bcf_pkg::FUNC_LOAD, 6, 7);
		push_cmd(bcf_pkg::FUNC_LOAD, 7, 5);
		push_cmd(bcf_pkg::FUNC_LOAD, 7, 8);
		push_cmd(bcf_pkg::FUNC_RUN, 0, 0);
		for (i = 0; i < 10; i++) push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		push_cmd(bcf_pkg::FUNC_LOAD, 8, 9);
		push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		drain();

		// shrunk vertex count, bad vertices
		write_vcount(3);
		push_cmd(bcf_pkg::FUNC_LOAD, 3, 0);
		push_cmd(bcf_pkg::FUNC_LOAD, 1, 1023);
		push_cmd(bcf_pkg::FUNC_LOAD, 0, 2);
		push_cmd(bcf_pkg::FUNC_RUN, 0, 0);
		for (i = 0; i < 5; i++) push_cmd(bcf_pkg::FUNC_READ, 0, 0);
		drain();

		issued = 0;
		while (issued < 650) begin
			if (issued >= 433) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (issued >= 216) begin
				send_idle = 45;
				recv_idle = 29;
			end
			k = $urandom_range(9);
			if (k == 0) nv = 1024;
			else if (k == 1) nv = 1;
			else nv = $urandom_range(2, 16);
			if (k == 9) write_vcount(2047);
			else write_vcount(nv);
			if (nv == 1024) nv = $urandom_range(2, 1024);
			random_graph(nv, issued);
			drain();
		end
		repeat (20) @(posedge clk);

		if (fails == 0) $display("[biconnected_component_finder] OK");
		else $display("[biconnected_component_finder] ERROR");
		$finish;
	end

endmodule

### biconnected_component_finder.f
sv/bcf_pkg.sv
sv/bcf_if.sv
sv/bcf_ram.sv
sv/bcf_engine.sv
sv/biconnected_component_finder.sv
sv/bcf_checker.sv
tb/biconnected_component_finder_tb.sv
